FILE: sv/erm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// erm_pkg : shared types and constants
// Beat types, pipeline control word and CORDIC constant generators for the
// XYZ Euler rotation matrix block.
// ----------------------------------------------------------------------------
package erm_pkg;

   localparam int ANGLE_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 14;
   localparam int FIELD_W        = 16;
   localparam int LANES          = 3;
   localparam int GUARD_BITS     = 26;
   localparam int ENTRIES        = 9;

   localparam real PI_R = 3.14159265358979323846;

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   typedef struct packed {
      logic [FIELD_W-1:0] angle_x;
      logic [FIELD_W-1:0] angle_y;
      logic [FIELD_W-1:0] angle_z;
   } erm_req_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] m_r0_c0;
      logic signed [FIELD_W-1:0] m_r0_c1;
      logic signed [FIELD_W-1:0] m_r0_c2;
      logic signed [FIELD_W-1:0] m_r1_c0;
      logic signed [FIELD_W-1:0] m_r1_c1;
      logic signed [FIELD_W-1:0] m_r1_c2;
      logic signed [FIELD_W-1:0] m_r2_c0;
      logic signed [FIELD_W-1:0] m_r2_c1;
      logic signed [FIELD_W-1:0] m_r2_c2;
   } erm_rsp_type;

   typedef struct packed {
      logic                  valid;
      logic [LANES-1:0][1:0] quad;
      logic [LANES-1:0]      swap;
   } erm_ctl_type;

   // arctangent of 2^-idx, scaled so that one octant is 2^zb
   function automatic longint atan_z(int zb, int idx);
      real r;
      r = $atan(2.0 ** (-idx)) * 4.0 / PI_R * (2.0 ** zb);
      return longint'(r);
   endfunction

   // CORDIC start vector length after n rotations, scaled by 2^fc
   function automatic longint gain_x(int fc, int n);
      real k;
      k = 1.0;
      for (int i = 0; i < n; i++) begin
         k = k * ((1.0 + 2.0 ** (-2 * i)) ** (-0.5));
      end
      return longint'(k * (2.0 ** fc));
   endfunction

endpackage
`default_nettype wire

FILE: sv/erm_fold.sv
`default_nettype none
// ----------------------------------------------------------------------------
// erm_fold : angle folding front end
// Reduces each binary angle to quadrant, octant swap and first-octant
// residual, and forms the starting vector for the rotation chain.
// ----------------------------------------------------------------------------
module erm_fold import erm_pkg::*; #(
   parameter int ANGLE_BITS = ANGLE_BITS_DEF,
   parameter int ZB         = FRAC_BITS_DEF + GUARD_BITS,
   parameter int ZW         = ZB + 2,
   parameter int XW         = FRAC_BITS_DEF + GUARD_BITS + 2,
   parameter int FC         = FRAC_BITS_DEF + GUARD_BITS,
   parameter int ITERS      = FRAC_BITS_DEF + GUARD_BITS - 2
) (
   input  wire logic                       beat,
   input  wire erm_req_type                payload,
   output erm_ctl_type                     ctl,
   output logic [LANES-1:0][XW-1:0]        x0,
   output logic [LANES-1:0][XW-1:0]        y0,
   output logic [LANES-1:0][ZW-1:0]        z0
);

   localparam logic [ANGLE_BITS-3:0] EIGHTH  = (ANGLE_BITS-2)'(1) << (ANGLE_BITS - 3);
   localparam logic [ANGLE_BITS-2:0] QUARTER = (ANGLE_BITS-1)'(1) << (ANGLE_BITS - 2);
   localparam logic [XW-1:0]         X_START = XW'(gain_x(FC, ITERS));

   logic [LANES-1:0][FIELD_W-1:0]    ang;
   logic [LANES-1:0][ANGLE_BITS-1:0] a_w;
   logic [LANES-1:0][ANGLE_BITS-3:0] r_w;
   logic [LANES-1:0][ANGLE_BITS-3:0] u_w;

   assign ang = {payload.angle_z, payload.angle_y, payload.angle_x};

   always_comb begin
      ctl.valid = beat;
      for (int l = 0; l < LANES; l++) begin
         a_w[l]         = ANGLE_BITS'(ang[l]);
         r_w[l]         = a_w[l][ANGLE_BITS-3:0];
         ctl.quad[l]    = a_w[l][ANGLE_BITS-1 -: 2];
         ctl.swap[l]    = r_w[l] > EIGHTH;
         u_w[l]         = ctl.swap[l] ? (ANGLE_BITS-2)'(QUARTER - {1'b0, r_w[l]}) : r_w[l];
         x0[l]          = X_START;
         y0[l]          = '0;
         z0[l]          = ZW'(u_w[l]) << (ZB - (ANGLE_BITS - 3));
      end
   end

endmodule
`default_nettype wire

FILE: sv/erm_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// erm_cell : one CORDIC rotation cell
// Applies rotation step IDX to the three angle lanes and hands the vectors
// and control word to the next cell.
// ----------------------------------------------------------------------------
module erm_cell import erm_pkg::*; #(
   parameter int IDX = 0,
   parameter int ZB  = FRAC_BITS_DEF + GUARD_BITS,
   parameter int ZW  = ZB + 2,
   parameter int XW  = FRAC_BITS_DEF + GUARD_BITS + 2
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       en,
   input  wire erm_ctl_type                prev_ctl,
   input  wire logic [LANES-1:0][XW-1:0]   prev_x,
   input  wire logic [LANES-1:0][XW-1:0]   prev_y,
   input  wire logic [LANES-1:0][ZW-1:0]   prev_z,
   output erm_ctl_type                     next_ctl,
   output logic [LANES-1:0][XW-1:0]        next_x,
   output logic [LANES-1:0][XW-1:0]        next_y,
   output logic [LANES-1:0][ZW-1:0]        next_z
);

   localparam logic [ZW-1:0] AT = ZW'(atan_z(ZB, IDX));

   erm_ctl_type              ctl_ff;
   logic [LANES-1:0][XW-1:0] x_ff, x_in;
   logic [LANES-1:0][XW-1:0] y_ff, y_in;
   logic [LANES-1:0][ZW-1:0] z_ff, z_in;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         if (prev_z[l][ZW-1]) begin
            x_in[l] = prev_x[l] + XW'($signed(prev_y[l]) >>> IDX);
            y_in[l] = prev_y[l] - XW'($signed(prev_x[l]) >>> IDX);
            z_in[l] = prev_z[l] + AT;
         end else begin
            x_in[l] = prev_x[l] - XW'($signed(prev_y[l]) >>> IDX);
            y_in[l] = prev_y[l] + XW'($signed(prev_x[l]) >>> IDX);
            z_in[l] = prev_z[l] - AT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= prev_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign next_ctl = ctl_ff;
   assign next_x   = x_ff;
   assign next_y   = y_ff;
   assign next_z   = z_ff;

endmodule
`default_nettype wire

FILE: sv/erm_matrix.sv
`default_nettype none
// ----------------------------------------------------------------------------
// erm_matrix : sine/cosine rounding and matrix product pipeline
// Rounds and unfolds the CORDIC vectors, forms pair and triple products and
// rounds each entry once with ties away from zero and saturation.
// ----------------------------------------------------------------------------
module erm_matrix import erm_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int FC        = FRAC_BITS_DEF + GUARD_BITS,
   parameter int XW        = FRAC_BITS_DEF + GUARD_BITS + 2
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       en,
   input  wire erm_ctl_type                prev_ctl,
   input  wire logic [LANES-1:0][XW-1:0]   prev_x,
   input  wire logic [LANES-1:0][XW-1:0]   prev_y,
   output logic                            out_valid,
   output erm_rsp_type                     out_data
);

   localparam int SW = FRAC_BITS + 2;
   localparam int PW = 2 * SW;
   localparam int TW = PW + SW;
   localparam int RS = FC - FRAC_BITS;
   localparam logic [XW-1:0] HALF_C = XW'(1) << (RS - 1);
   localparam logic [TW-1:0] HALF_E = TW'(1) << (2 * FRAC_BITS - 1);
   localparam logic [TW-1:0] ONE_E  = TW'(1) << FRAC_BITS;

   // stage 0: rounded sine and cosine
   logic [LANES-1:0][XW-1:0] xr, yr;
   logic [LANES-1:0][SW-1:0] c_w, s_w;
   logic [LANES-1:0][SW-1:0] sn_in, cs_in, sn_ff, cs_ff;
   logic                     v0_ff;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         xr[l] = XW'($signed(prev_x[l] + HALF_C) >>> RS);
         yr[l] = XW'($signed(prev_y[l] + HALF_C) >>> RS);
         c_w[l] = prev_ctl.swap[l] ? yr[l][SW-1:0] : xr[l][SW-1:0];
         s_w[l] = prev_ctl.swap[l] ? xr[l][SW-1:0] : yr[l][SW-1:0];
         unique case (prev_ctl.quad[l])
            QUAD_0: begin
               sn_in[l] = s_w[l];
               cs_in[l] = c_w[l];
            end
            QUAD_1: begin
               sn_in[l] = c_w[l];
               cs_in[l] = SW'(0) - s_w[l];
            end
            QUAD_2: begin
               sn_in[l] = SW'(0) - s_w[l];
               cs_in[l] = SW'(0) - c_w[l];
            end
            QUAD_3: begin
               sn_in[l] = SW'(0) - c_w[l];
               cs_in[l] = s_w[l];
            end
            default: begin
               sn_in[l] = s_w[l];
               cs_in[l] = c_w[l];
            end
         endcase
      end
   end

   // stage 1: pair products
   logic signed [SW-1:0] sx, cx, sy, cy, sz, cz;
   logic signed [PW-1:0] p_in [ENTRIES];
   logic signed [PW-1:0] p_ff [ENTRIES];
   logic signed [PW-1:0] sxsy_ff, cxsy_ff;
   logic signed [SW-1:0] szd_ff, czd_ff;
   logic                 v1_ff;

   assign sx = $signed(sn_ff[0]);
   assign cx = $signed(cs_ff[0]);
   assign sy = $signed(sn_ff[1]);
   assign cy = $signed(cs_ff[1]);
   assign sz = $signed(sn_ff[2]);
   assign cz = $signed(cs_ff[2]);

   always_comb begin
      p_in[0] = cy * cz;
      p_in[1] = -(cy * sz);
      p_in[2] = PW'(sy) <<< FRAC_BITS;
      p_in[3] = cx * sz;
      p_in[4] = cx * cz;
      p_in[5] = -(sx * cy);
      p_in[6] = sx * sz;
      p_in[7] = sx * cz;
      p_in[8] = cx * cy;
   end

   // stage 2: aligned pairs and triple products
   logic signed [TW-1:0] a_ff [ENTRIES];
   logic signed [TW-1:0] t_in [ENTRIES];
   logic signed [TW-1:0] t_ff [ENTRIES];
   logic                 v2_ff;

   always_comb begin
      for (int k = 0; k < ENTRIES; k++) begin
         t_in[k] = '0;
      end
      t_in[3] = sxsy_ff * czd_ff;
      t_in[4] = -(sxsy_ff * szd_ff);
      t_in[6] = -(cxsy_ff * czd_ff);
      t_in[7] = cxsy_ff * szd_ff;
   end

   // stage 3: sum, round and saturate
   logic [TW-1:0]                  sum_w [ENTRIES];
   logic [TW-1:0]                  mag_w [ENTRIES];
   logic [TW-1:0]                  rnd_w [ENTRIES];
   logic [TW-1:0]                  val_w [ENTRIES];
   logic [ENTRIES-1:0][FIELD_W-1:0] ent_in;
   erm_rsp_type                    out_ff, out_in;
   logic                           v3_ff;

   always_comb begin
      for (int k = 0; k < ENTRIES; k++) begin
         sum_w[k] = a_ff[k] + t_ff[k];
         mag_w[k] = sum_w[k][TW-1] ? TW'(0) - sum_w[k] : sum_w[k];
         rnd_w[k] = (mag_w[k] + HALF_E) >> (2 * FRAC_BITS);
         if (rnd_w[k] > ONE_E) begin
            rnd_w[k] = ONE_E;
         end
         val_w[k]  = sum_w[k][TW-1] ? TW'(0) - rnd_w[k] : rnd_w[k];
         ent_in[k] = val_w[k][FIELD_W-1:0];
      end
      out_in.m_r0_c0 = ent_in[0];
      out_in.m_r0_c1 = ent_in[1];
      out_in.m_r0_c2 = ent_in[2];
      out_in.m_r1_c0 = ent_in[3];
      out_in.m_r1_c1 = ent_in[4];
      out_in.m_r1_c2 = ent_in[5];
      out_in.m_r2_c0 = ent_in[6];
      out_in.m_r2_c1 = ent_in[7];
      out_in.m_r2_c2 = ent_in[8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= prev_ctl.valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sn_ff   <= sn_in;
         cs_ff   <= cs_in;
         p_ff    <= p_in;
         sxsy_ff <= sx * sy;
         cxsy_ff <= cx * sy;
         szd_ff  <= sz;
         czd_ff  <= cz;
         for (int k = 0; k < ENTRIES; k++) begin
            a_ff[k] <= TW'(p_ff[k]) <<< FRAC_BITS;
         end
         t_ff    <= t_in;
         out_ff  <= out_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = out_ff;

endmodule
`default_nettype wire

FILE: sv/euler_rotation_matrix_top.sv
`default_nettype none
// A request passes the CORDIC cell chain, the matrix product pipeline and the
//   output register. Throughput: one beat per cycle while not stalled;
//   an output skid register absorbs one stalled beat.
// Reset clears the valid bits of every stage and the output; data holds no reset.
// ----------------------------------------------------------------------------
// euler_rotation_matrix_top : XYZ Euler rotation matrix
// Turns three binary angles into the nine Q1.FRAC_BITS entries of Rx*Ry*Rz
// through a chain of CORDIC cells and a product pipeline.
// ----------------------------------------------------------------------------
module euler_rotation_matrix_top import erm_pkg::*; #(
   parameter int ANGLE_BITS = ANGLE_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire erm_req_type req_payload,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output erm_rsp_type      rsp_payload
);

   localparam int FC    = FRAC_BITS + GUARD_BITS;
   localparam int ZB    = FC;
   localparam int ZW    = ZB + 2;
   localparam int XW    = FC + 2;
   localparam int ITERS = FC - 2;

   logic                     en;
   erm_ctl_type              ctl_c [ITERS+1];
   logic [LANES-1:0][XW-1:0] x_c   [ITERS+1];
   logic [LANES-1:0][XW-1:0] y_c   [ITERS+1];
   logic [LANES-1:0][ZW-1:0] z_c   [ITERS+1];
   logic                     mat_valid;
   erm_rsp_type              mat_data;
   logic                     rsp_valid_ff, skid_v_ff;
   erm_rsp_type              rsp_payload_ff, skid_ff;
   logic                     out_free;

   assign en        = !skid_v_ff;
   assign req_stall = skid_v_ff;

   erm_fold #(
      .ANGLE_BITS (ANGLE_BITS),
      .ZB         (ZB),
      .ZW         (ZW),
      .XW         (XW),
      .FC         (FC),
      .ITERS      (ITERS)
   ) u_fold (
      .beat    (req_valid && en),
      .payload (req_payload),
      .ctl     (ctl_c[0]),
      .x0      (x_c[0]),
      .y0      (y_c[0]),
      .z0      (z_c[0])
   );

   for (genvar i = 0; i < ITERS; i++) begin : g_cell
      erm_cell #(
         .IDX (i),
         .ZB  (ZB),
         .ZW  (ZW),
         .XW  (XW)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .prev_ctl (ctl_c[i]),
         .prev_x   (x_c[i]),
         .prev_y   (y_c[i]),
         .prev_z   (z_c[i]),
         .next_ctl (ctl_c[i+1]),
         .next_x   (x_c[i+1]),
         .next_y   (y_c[i+1]),
         .next_z   (z_c[i+1])
      );
   end

   erm_matrix #(
      .FRAC_BITS (FRAC_BITS),
      .FC        (FC),
      .XW        (XW)
   ) u_matrix (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .prev_ctl  (ctl_c[ITERS]),
      .prev_x    (x_c[ITERS]),
      .prev_y    (y_c[ITERS]),
      .out_valid (mat_valid),
      .out_data  (mat_data)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_v_ff    <= 1'b0;
      end else if (skid_v_ff) begin
         if (out_free) begin
            rsp_valid_ff <= 1'b1;
            skid_v_ff    <= 1'b0;
         end
      end else if (mat_valid) begin
         if (out_free) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_v_ff <= 1'b1;
         end
      end else if (out_free) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff && out_free) begin
         rsp_payload_ff <= skid_ff;
      end else if (!skid_v_ff && mat_valid && out_free) begin
         rsp_payload_ff <= mat_data;
      end
      if (!skid_v_ff && mat_valid && !out_free) begin
         skid_ff <= mat_data;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> rsp_valid_ff)
      else $error("skid holds a beat while the output register is empty");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(rsp_valid_ff && rsp_stall))
      else $error("skid filled without a stalled output beat");

   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff && !rsp_stall |=> rsp_valid_ff && !skid_v_ff)
      else $error("skid beat not moved to the output");

endmodule
`default_nettype wire

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb : euler_rotation_matrix_top bench
// Drives corner triples, then random bursts, against a stalling receiver and
// checks every matrix beat against an exact fixed-point model of Rx*Ry*Rz.
// ----------------------------------------------------------------------------
module tb;
   import erm_pkg::*;

   localparam int  AB        = ANGLE_BITS_DEF;
   localparam int  FB        = FRAC_BITS_DEF;
   localparam int  LATENCY   = FB + GUARD_BITS + 3;
   localparam int  N_RANDOM  = 500;
   localparam logic [63:0] Q62_ONE = 64'd1 << 62;
   localparam logic [63:0] PI4_Q64 = 64'hC90FDAA22168C234;

   typedef struct { bit neg; logic [63:0] mag; } sv_t;
   typedef struct { bit neg; logic [127:0] mag; } wv_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   erm_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   erm_rsp_type rsp_payload;
   int          beats_in = 0;
   int          beats_out = 0;

   always #2 clock = ~clock;

   function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = a * b;
      return p[125:62];
   endfunction

   function automatic logic [63:0] round_q62(logic [63:0] v);
      return (v + (64'd1 << (61 - FB))) >> (62 - FB);
   endfunction

   function automatic void sin_cos(logic [15:0] ang, output sv_t sn, output sv_t cs);
      logic [63:0] a, r, u, x, x2, ts, tc, s, c, t, dn;
      logic [127:0] p;
      logic [1:0] q;
      bit swp;
      a = ang & ((64'd1 << AB) - 1);
      q = a >> (AB - 2);
      r = a & ((64'd1 << (AB - 2)) - 1);
      swp = r > (64'd1 << (AB - 3));
      u = swp ? (64'd1 << (AB - 2)) - r : r;
      p = u * PI4_Q64;
      x = p >> (AB - 1);
      x2 = mul_q62(x, x);
      ts = Q62_ONE;
      tc = Q62_ONE;
      for (int n = 10; n >= 1; n--) begin
         dn = n;
         ts = Q62_ONE - mul_q62(x2, ts) / ((2 * dn) * (2 * dn + 1));
         tc = Q62_ONE - mul_q62(x2, tc) / ((2 * dn - 1) * (2 * dn));
      end
      s = round_q62(mul_q62(x, ts));
      c = round_q62(tc);
      if (swp) begin
         t = s; s = c; c = t;
      end
      case (q)
         QUAD_0: begin sn = '{0, s}; cs = '{0, c}; end
         QUAD_1: begin sn = '{0, c}; cs = '{1, s}; end
         QUAD_2: begin sn = '{1, s}; cs = '{1, c}; end
         default: begin sn = '{1, c}; cs = '{0, s}; end
      endcase
   endfunction

   function automatic wv_t triple(sv_t a, sv_t b, sv_t c, bit flip);
      wv_t w;
      w.mag = a.mag * b.mag * c.mag;
      w.neg = a.neg ^ b.neg ^ c.neg ^ flip;
      return w;
   endfunction

   function automatic logic [15:0] round_entry(wv_t p, wv_t q);
      logic [127:0] m;
      bit neg;
      if (p.neg == q.neg) begin
         m = p.mag + q.mag;
         neg = p.neg;
      end else if (p.mag >= q.mag) begin
         m = p.mag - q.mag;
         neg = p.neg;
      end else begin
         m = q.mag - p.mag;
         neg = q.neg;
      end
      m = (m + (128'd1 << (2 * FB - 1))) >> (2 * FB);
      if (m > (128'd1 << FB)) m = 128'd1 << FB;
      return neg ? 16'(-m) : 16'(m);
   endfunction

   function automatic erm_rsp_type rotation_matrix(erm_req_type r);
      sv_t sx, cx, sy, cy, sz, cz, one;
      wv_t zero;
      erm_rsp_type m;
      sin_cos(r.angle_x, sx, cx);
      sin_cos(r.angle_y, sy, cy);
      sin_cos(r.angle_z, sz, cz);
      one = '{0, 64'd1 << FB};
      zero = '{0, 128'd0};
      m.m_r0_c0 = round_entry(triple(cy, cz, one, 0), zero);
      m.m_r0_c1 = round_entry(triple(cy, sz, one, 1), zero);
      m.m_r0_c2 = round_entry(triple(sy, one, one, 0), zero);
      m.m_r1_c0 = round_entry(triple(cx, sz, one, 0), triple(sx, sy, cz, 0));
      m.m_r1_c1 = round_entry(triple(cx, cz, one, 0), triple(sx, sy, sz, 1));
      m.m_r1_c2 = round_entry(triple(sx, cy, one, 1), zero);
      m.m_r2_c0 = round_entry(triple(sx, sz, one, 0), triple(cx, sy, cz, 1));
      m.m_r2_c1 = round_entry(triple(sx, cz, one, 0), triple(cx, sy, sz, 0));
      m.m_r2_c2 = round_entry(triple(cx, cy, one, 0), zero);
      return m;
   endfunction

   class matrix_board;
      erm_rsp_type pending[$];
      int errors = 0;

      function void note_angles(erm_req_type r);
         pending.push_back(rotation_matrix(r));
      endfunction

      function void check_matrix(erm_rsp_type got);
         erm_rsp_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected beat %h", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         for (int i = 0; i < ENTRIES; i++) begin
            if (want[i*16 +: 16] !== got[i*16 +: 16]) begin
               $display("%0t: entry %0d expected %h actual %h", $time, ENTRIES - 1 - i,
                        want[i*16 +: 16], got[i*16 +: 16]);
               errors++;
            end
         end
      endfunction
   endclass

   matrix_board board = new();

   euler_rotation_matrix_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
   );

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         board.note_angles(req_payload);
         beats_in++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_matrix(rsp_payload);
         beats_out++;
      end
   end

   // receiver stall pattern: quiet stretches, sparse and dense random stalls
   always @(posedge clock) begin
      case ((beats_out / 64) % 3)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 1) == 0);
      endcase
   end

   task automatic send_angles(logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
      req_valid <= 1'b1;
      req_payload <= '{ax, ay, az};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic idle_sender(int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_angle();
      case ($urandom_range(0, 3))
         0: return 16'($urandom_range(0, 7)) << 13;
         1: return (16'($urandom_range(0, 7)) << 13) + 16'($urandom_range(0, 4)) - 16'd2;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      logic [15:0] corner[8] = '{16'h0000, 16'h2000, 16'h4000, 16'h6000,
                                 16'h8000, 16'hC000, 16'hFFFF, 16'h1FFF};
      int left;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < 8; i++) send_angles(corner[i], corner[(i + 3) % 8], corner[7 - i]);
      send_angles(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_angles(16'h2001, 16'h1FFF, 16'h5555);
      send_angles(16'hAAAA, 16'h5555, 16'h2000);
      idle_sender(1);
      while (board.pending.size() != 0) @(posedge clock);
      left = N_RANDOM;
      while (left > 0) begin
         for (int b = $urandom_range(1, 24); b > 0 && left > 0; b--, left--)
            send_angles(pick_angle(), pick_angle(), pick_angle());
         if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 6));
      end
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      $display("Sent %0d angle triples, checked %0d matrices (directed corners and random bursts).",
               beats_in, beats_out);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #400000;
      $display("Timeout");
      $display("Test completed with failures");
      $finish;
   end
endmodule
